/* src/pip_pkg.sv */
// shared constants, control word types and microprogram for the point in polygon tester
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 128;
    localparam int COORD_BITS_DEF   = 16;
    localparam int COUNT_OUT_W      = 8;
    localparam int OP_W             = 2;
    localparam int OUT_W            = 16;
    localparam int MIN_POLY         = 3;
    localparam int UPC_W            = 4;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_FIRST,
        MUL_SECOND
    } mul_sel_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ALWAYS,
        J_NOSTART,
        J_MORE
    } jcond_t;

    typedef struct packed {
        logic             clr;
        logic             mem_rd;
        logic             ld_first;
        logic             ld_cur_mem;
        logic             ld_cur_first;
        mul_sel_t         mul_sel;
        logic             eval;
        logic             shift;
        logic             done;
        jcond_t           jcond;
        logic [UPC_W-1:0] jtarget;
    } ucw_t;

    typedef struct packed {
        logic more;
        logic in_poly;
    } dp_status_t;

    localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] U_RD0    = 4'd1;
    localparam logic [UPC_W-1:0] U_LDF    = 4'd2;
    localparam logic [UPC_W-1:0] U_LDC    = 4'd3;
    localparam logic [UPC_W-1:0] U_MUL1   = 4'd4;
    localparam logic [UPC_W-1:0] U_MUL2   = 4'd5;
    localparam logic [UPC_W-1:0] U_EVAL   = 4'd6;
    localparam logic [UPC_W-1:0] U_LDCF   = 4'd7;
    localparam logic [UPC_W-1:0] U_CMUL1  = 4'd8;
    localparam logic [UPC_W-1:0] U_CMUL2  = 4'd9;
    localparam logic [UPC_W-1:0] U_CEVAL  = 4'd10;
    localparam logic [UPC_W-1:0] U_DONE   = 4'd11;

    function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucw_t w;
        w = '0;
        unique case (addr)
            U_IDLE:
            begin
                w.clr     = 1'b1;
                w.jcond   = J_NOSTART;
                w.jtarget = U_IDLE;
            end
            U_RD0:
            begin
                w.mem_rd = 1'b1;
            end
            U_LDF:
            begin
                w.ld_first = 1'b1;
                w.mem_rd   = 1'b1;
            end
            U_LDC:
            begin
                w.ld_cur_mem = 1'b1;
            end
            U_MUL1, U_CMUL1:
            begin
                w.mul_sel = MUL_FIRST;
            end
            U_MUL2, U_CMUL2:
            begin
                w.mul_sel = MUL_SECOND;
            end
            U_EVAL:
            begin
                w.eval    = 1'b1;
                w.shift   = 1'b1;
                w.mem_rd  = 1'b1;
                w.jcond   = J_MORE;
                w.jtarget = U_LDC;
            end
            U_LDCF:
            begin
                w.ld_cur_first = 1'b1;
            end
            U_CEVAL:
            begin
                w.eval = 1'b1;
            end
            U_DONE:
            begin
                w.done    = 1'b1;
                w.jcond   = J_ALWAYS;
                w.jtarget = U_IDLE;
            end
            default:
            begin
                w.jcond   = J_ALWAYS;
                w.jtarget = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/pip_vstore.sv */
// vertex memory, one write port and one registered read port
module pip_vstore
    import pip_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF,
    parameter int WIDTH = 2 * COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pip_sequencer.sv */
// microprogram counter, control store and jump logic
module pip_sequencer
    import pip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ucw_t       ctrl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctrl.jcond)
            J_NEXT:    take = 1'b0;
            J_ALWAYS:  take = 1'b1;
            J_NOSTART: take = !start;
            J_MORE:    take = status.more;
            default:   take = 1'b1;
        endcase
        upc_next = take ? ctrl.jtarget : upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* src/pip_datapath.sv */
// edge walk datapath: vertex registers, shared multiplier, crossing parities
module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ucw_t                                  ctrl,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     n_vert,
    input  logic signed [COORD_BITS-1:0]          px,
    input  logic signed [COORD_BITS-1:0]          py,
    output logic                                  rd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr,
    input  logic [2*COORD_BITS-1:0]               rd_data,
    output dp_status_t                            status
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CB = COORD_BITS;
    localparam int D  = COORD_BITS + 1;
    localparam int PW = 2 * D;

    logic [CW-1:0]          idx_reg;
    logic signed [CB-1:0]   first_x_reg, first_y_reg;
    logic signed [CB-1:0]   prev_x_reg, prev_y_reg;
    logic signed [CB-1:0]   cur_x_reg, cur_y_reg;
    logic signed [PW-1:0]   p1_reg, p2_reg;
    logic                   tot_par_reg, abv_par_reg;

    logic signed [CB-1:0]   mem_x, mem_y;
    logic                   swap;
    logic signed [CB-1:0]   xa, ya, xb, yb;
    logic signed [D-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW:0]     sum;
    logic                   hit, above;

    assign mem_x = rd_data[CB-1:0];
    assign mem_y = rd_data[2*CB-1:CB];

    assign rd_en   = ctrl.mem_rd;
    assign rd_addr = idx_reg[AW-1:0];

    // order the edge so that xa <= xb
    assign swap = cur_x_reg < prev_x_reg;
    assign xa   = swap ? cur_x_reg  : prev_x_reg;
    assign ya   = swap ? cur_y_reg  : prev_y_reg;
    assign xb   = swap ? prev_x_reg : cur_x_reg;
    assign yb   = swap ? prev_y_reg : cur_y_reg;

    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_FIRST:
            begin
                mul_a = $signed({ya[CB-1], ya}) - $signed({py[CB-1], py});
                mul_b = $signed({xb[CB-1], xb}) - $signed({xa[CB-1], xa});
            end
            MUL_SECOND:
            begin
                mul_a = $signed({yb[CB-1], yb}) - $signed({ya[CB-1], ya});
                mul_b = $signed({px[CB-1], px}) - $signed({xa[CB-1], xa});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign sum   = $signed({p1_reg[PW-1], p1_reg}) + $signed({p2_reg[PW-1], p2_reg});
    assign above = !sum[PW] && (sum != '0);
    assign hit   = (px >= prev_x_reg && px < cur_x_reg) || (px < prev_x_reg && px >= cur_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            tot_par_reg <= 1'b0;
            abv_par_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr)
            begin
                idx_reg     <= '0;
                tot_par_reg <= 1'b0;
                abv_par_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.mem_rd)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (ctrl.eval)
                begin
                    tot_par_reg <= tot_par_reg ^ hit;
                    abv_par_reg <= abv_par_reg ^ (hit && above);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_first)
        begin
            first_x_reg <= mem_x;
            first_y_reg <= mem_y;
            prev_x_reg  <= mem_x;
            prev_y_reg  <= mem_y;
        end
        else if (ctrl.shift)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (ctrl.ld_cur_mem)
        begin
            cur_x_reg <= mem_x;
            cur_y_reg <= mem_y;
        end
        else if (ctrl.ld_cur_first)
        begin
            cur_x_reg <= first_x_reg;
            cur_y_reg <= first_y_reg;
        end
        if (ctrl.mul_sel == MUL_FIRST)
        begin
            p1_reg <= prod;
        end
        if (ctrl.mul_sel == MUL_SECOND)
        begin
            p2_reg <= prod;
        end
    end

    assign status.more    = (idx_reg != n_vert);
    assign status.in_poly = !tot_par_reg && abv_par_reg;

endmodule

/* src/point_in_polygon_test.sv */
// top level: item decode, vertex count, output register and polygon test sequencing
// append, delete, unused op and a test of fewer than three vertices: result in the cycle after
// the input transfer. a test of n >= 3 vertices: result when the microprogram reaches its done step,
// four microsteps per edge around the shared multiplier and the single memory read port.
// one item in work at a time; the next input is taken as the output register empties.
// reset clears the vertex count, sequencer and handshake state; vertex memory is not cleared.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,  // coord_x, coord_y
    input  logic [OP_W-1:0]                     s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata   // inside_res, accepted, vertex_count
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CB = COORD_BITS;

    logic                   in_xfer;
    logic [OP_W-1:0]        op;
    logic signed [CB-1:0]   cx, cy;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, start_reg;
    logic signed [CB-1:0]   px_reg, py_reg;
    logic                   m_tvalid_reg;
    logic                   inside_reg, acc_reg;
    logic                   acc_next;
    logic                   test_go;
    logic                   wr_en;

    ucw_t                   ctrl;
    dp_status_t             status;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [2*CB-1:0]        rd_data;

    assign op  = s_tuser;
    assign cx  = s_tdata[CB-1:0];
    assign cy  = s_tdata[2*CB-1:CB];

    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = 1'b1;
        wr_en    = 1'b0;
        test_go  = 1'b0;
        unique case (op)
            OP_APPEND:
            begin
                if (cnt_reg == CW'(MAX_VERTICES))
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    wr_en    = in_xfer;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_TEST:
            begin
                test_go = (cnt_reg >= CW'(MIN_POLY));
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_xfer)
            begin
                cnt_reg <= cnt_next;
                if (test_go)
                begin
                    busy_reg  <= 1'b1;
                    start_reg <= 1'b1;
                end
                else
                begin
                    m_tvalid_reg <= 1'b1;
                end
            end
            if (ctrl.done)
            begin
                busy_reg     <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg     <= cx;
            py_reg     <= cy;
            inside_reg <= 1'b0;
            acc_reg    <= acc_next;
        end
        if (ctrl.done)
        begin
            inside_reg <= status.in_poly;
            acc_reg    <= 1'b1;
        end
    end

    pip_vstore #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CB)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({cy, cx}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .status (status),
        .ctrl   (ctrl)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .n_vert  (cnt_reg),
        .px      (px_reg),
        .py      (py_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .status  (status)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({COUNT_OUT_W'(cnt_reg), acc_reg, inside_reg});

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done |-> (busy_reg && !m_tvalid_reg))
        else $error("test finished while idle or with output pending");

    a_test_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && test_go) |=> (!m_tvalid_reg && busy_reg))
        else $error("output shown before test completed");

    a_no_count_change_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(cnt_reg))
        else $error("vertex count changed during test");

endmodule
